// ===== design/gnig_pkg.sv =====
// Shared types, constants and the sequencer microprogram for the grid neighbour index generator.
package gnig_pkg;

   localparam int unsigned IDX_W          = 24;
   localparam int unsigned CSR_DATA_W     = 9;
   localparam int unsigned DIV_RADIX_BITS = 2;
   localparam int unsigned DIV_STEPS      = IDX_W / DIV_RADIX_BITS;
   localparam int unsigned DIV_CNT_W      = $clog2(DIV_STEPS);
   localparam int unsigned NBR_POS        = 27;

   // Position p = 9*a + 3*b + d, where a, b, d are the x, y, z offsets plus one
   localparam logic [NBR_POS-1:0] X_NEG_MASK  = 27'h00001FF;
   localparam logic [NBR_POS-1:0] X_POS_MASK  = 27'h7FC0000;
   localparam logic [NBR_POS-1:0] Y_NEG_MASK  = 27'h01C0E07;
   localparam logic [NBR_POS-1:0] Y_POS_MASK  = 27'h70381C0;
   localparam logic [NBR_POS-1:0] Z_NEG_MASK  = 27'h1249249;
   localparam logic [NBR_POS-1:0] Z_POS_MASK  = 27'h4924924;
   localparam logic [NBR_POS-1:0] CENTER_MASK = 27'h0002000;

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_EMPTY   = 2'd1,
      STATUS_OUTSIDE = 2'd2
   } status_type;

   typedef enum logic {
      CSR_GRID_SIDE = 1'b0,
      CSR_RADIUS    = 1'b1
   } csr_addr_type;

   typedef enum logic [2:0] {
      COND_ALWAYS    = 3'd0,
      COND_REQ       = 3'd1,
      COND_DIV_DONE  = 3'd2,
      COND_OUTSIDE   = 3'd3,
      COND_RUN_DONE  = 3'd4,
      COND_SLOT_FREE = 3'd5
   } cond_type;

   typedef logic [2:0] upc_type;

   localparam upc_type UPC_WAIT   = 3'd0;
   localparam upc_type UPC_DIV_X  = 3'd1;
   localparam upc_type UPC_MOVE_X = 3'd2;
   localparam upc_type UPC_DIV_Y  = 3'd3;
   localparam upc_type UPC_SPLIT  = 3'd4;
   localparam upc_type UPC_MASK   = 3'd5;
   localparam upc_type UPC_EMIT   = 3'd6;
   localparam upc_type UPC_ERROR  = 3'd7;

   typedef struct packed {
      logic     take_req;
      logic     div_step;
      logic     move_x;
      logic     take_yz;
      logic     make_mask;
      logic     emit_nbr;
      logic     emit_err;
      cond_type cond;
      upc_type  go_true;
      upc_type  go_false;
   } ucode_word_type;

   function automatic ucode_word_type ucode_rom(input upc_type upc);
      ucode_word_type w;
      w          = '0;
      w.cond     = COND_ALWAYS;
      w.go_true  = UPC_WAIT;
      w.go_false = UPC_WAIT;
      case (upc)
         UPC_WAIT: begin
            w.take_req = 1'b1;
            w.cond     = COND_REQ;
            w.go_true  = UPC_DIV_X;
            w.go_false = UPC_WAIT;
         end
         UPC_DIV_X: begin
            w.div_step = 1'b1;
            w.cond     = COND_DIV_DONE;
            w.go_true  = UPC_MOVE_X;
            w.go_false = UPC_DIV_X;
         end
         UPC_MOVE_X: begin
            w.move_x  = 1'b1;
            w.go_true = UPC_DIV_Y;
         end
         UPC_DIV_Y: begin
            w.div_step = 1'b1;
            w.cond     = COND_DIV_DONE;
            w.go_true  = UPC_SPLIT;
            w.go_false = UPC_DIV_Y;
         end
         UPC_SPLIT: begin
            w.take_yz  = 1'b1;
            w.cond     = COND_OUTSIDE;
            w.go_true  = UPC_ERROR;
            w.go_false = UPC_MASK;
         end
         UPC_MASK: begin
            w.make_mask = 1'b1;
            w.go_true   = UPC_EMIT;
         end
         UPC_EMIT: begin
            w.emit_nbr = 1'b1;
            w.cond     = COND_RUN_DONE;
            w.go_true  = UPC_WAIT;
            w.go_false = UPC_EMIT;
         end
         UPC_ERROR: begin
            w.emit_err = 1'b1;
            w.cond     = COND_SLOT_FREE;
            w.go_true  = UPC_WAIT;
            w.go_false = UPC_ERROR;
         end
         default: begin
            w.go_true = UPC_WAIT;
         end
      endcase
      return w;
   endfunction

endpackage

// ===== design/grid_neighbor_index_generator_top.sv =====
// Grid neighbour index generator: microcoded sequencer, shared divider and output word register.

// Takes one centre index at a time and returns the linear indices of its in-grid neighbours,
// x offset outermost, then y, then z, with rsp_last on the final word. A new centre is
// accepted only after the final word of the previous one has been loaded for output. The
// restoring divider retires two quotient bits a cycle and runs twice (x, then y and z), and
// the output register takes one word a cycle while rsp_ready does not stall it. A centre at
// or beyond the grid volume gives a single word with status 2; radius 0 or a side of one
// gives a single word with status 1. Configuration writes are taken in any cycle; change
// them only while no item is in flight.
module grid_neighbor_index_generator_top
   import gnig_pkg::*;
#(
   parameter int unsigned MAX_GRID_SIDE = 256
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [IDX_W-1:0]      req_center_index,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [IDX_W-1:0]      rsp_neighbor_index,
   output logic [1:0]            rsp_status,
   output logic                  rsp_last,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic                  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   localparam int unsigned SIDE_W = $clog2(MAX_GRID_SIDE + 1);
   localparam int unsigned COORD_W = $clog2(MAX_GRID_SIDE);
   localparam int unsigned SQ_W = 2 * SIDE_W;
   localparam logic [CSR_DATA_W-1:0] MAX_SIDE_C = CSR_DATA_W'(MAX_GRID_SIDE);

   upc_type               upc_ff, upc_in;
   logic [CSR_DATA_W-1:0] grid_side_ff, grid_side_in;
   logic                  radius_ff, radius_in;
   logic [IDX_W-1:0]      center_index_ff, center_index_in;
   logic [SIDE_W-1:0]     rem_ff, rem_in;
   logic [IDX_W-1:0]      quo_ff, quo_in;
   logic [DIV_CNT_W-1:0]  div_cnt_ff, div_cnt_in;
   logic [COORD_W-1:0]    center_x_ff, center_x_in;
   logic [COORD_W-1:0]    center_y_ff, center_y_in;
   logic [COORD_W-1:0]    center_z_ff, center_z_in;
   logic [NBR_POS-1:0]    mask_ff, mask_in;
   logic [SQ_W-1:0]       side_sq_ff, side_sq_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0]      rsp_index_ff, rsp_index_in;
   status_type            rsp_status_ff, rsp_status_in;
   logic                  rsp_last_ff, rsp_last_in;

   ucode_word_type        uword;
   logic                  req_fire;
   logic                  slot_free;
   logic                  cond_true;
   logic                  rsp_load;
   logic [SIDE_W-1:0]     side;
   logic [SIDE_W-1:0]     part_rem;
   logic [IDX_W-1:0]      part_quo;
   logic [SIDE_W:0]       trial;
   logic                  outside;
   logic [NBR_POS-1:0]    mask_new;
   logic [NBR_POS-1:0]    pick;
   logic [NBR_POS-1:0]    rest;
   logic [IDX_W-1:0]      x_add, y_add, z_add;
   logic [IDX_W-1:0]      nbr_index;

   // Effective side, the divider step and the outside check
   always_comb begin
      if (grid_side_ff == '0) begin
         side = SIDE_W'(1);
      end else if (grid_side_ff > MAX_SIDE_C) begin
         side = SIDE_W'(MAX_GRID_SIDE);
      end else begin
         side = grid_side_ff[SIDE_W-1:0];
      end

      part_rem = rem_ff;
      part_quo = quo_ff;
      trial    = '0;
      for (int i = 0; i < DIV_RADIX_BITS; i++) begin
         trial    = {part_rem, part_quo[IDX_W-1]};
         part_quo = {part_quo[IDX_W-2:0], 1'b0};
         if (trial >= {1'b0, side}) begin
            trial       = trial - {1'b0, side};
            part_quo[0] = 1'b1;
         end
         part_rem = trial[SIDE_W-1:0];
      end

      outside = quo_ff >= IDX_W'(side);
   end

   // Neighbour mask and the next word's index
   always_comb begin
      mask_new = '0;
      if (radius_ff) begin
         mask_new = ~CENTER_MASK;
         if (center_x_ff == '0) mask_new = mask_new & ~X_NEG_MASK;
         if (SIDE_W'(center_x_ff) == side - SIDE_W'(1)) mask_new = mask_new & ~X_POS_MASK;
         if (center_y_ff == '0) mask_new = mask_new & ~Y_NEG_MASK;
         if (SIDE_W'(center_y_ff) == side - SIDE_W'(1)) mask_new = mask_new & ~Y_POS_MASK;
         if (center_z_ff == '0) mask_new = mask_new & ~Z_NEG_MASK;
         if (SIDE_W'(center_z_ff) == side - SIDE_W'(1)) mask_new = mask_new & ~Z_POS_MASK;
      end

      pick = mask_ff & (~mask_ff + NBR_POS'(1));
      rest = mask_ff & (mask_ff - NBR_POS'(1));

      if ((pick & X_NEG_MASK) != '0) begin
         x_add = '1;
      end else if ((pick & X_POS_MASK) != '0) begin
         x_add = IDX_W'(1);
      end else begin
         x_add = '0;
      end
      if ((pick & Y_NEG_MASK) != '0) begin
         y_add = IDX_W'(0) - IDX_W'(side);
      end else if ((pick & Y_POS_MASK) != '0) begin
         y_add = IDX_W'(side);
      end else begin
         y_add = '0;
      end
      if ((pick & Z_NEG_MASK) != '0) begin
         z_add = IDX_W'(0) - IDX_W'(side_sq_ff);
      end else if ((pick & Z_POS_MASK) != '0) begin
         z_add = IDX_W'(side_sq_ff);
      end else begin
         z_add = '0;
      end
      // wraps modulo the index width; the true neighbour always lies in range
      nbr_index = center_index_ff + x_add + y_add + z_add;
   end

   // Sequencer: fetch, evaluate the jump condition, pick the next step
   always_comb begin
      uword     = ucode_rom(upc_ff);
      slot_free = !rsp_valid_ff || rsp_ready;
      req_fire  = req_valid && uword.take_req;
      case (uword.cond)
         COND_ALWAYS:    cond_true = 1'b1;
         COND_REQ:       cond_true = req_fire;
         COND_DIV_DONE:  cond_true = div_cnt_ff == DIV_CNT_W'(DIV_STEPS - 1);
         COND_OUTSIDE:   cond_true = outside;
         COND_RUN_DONE:  cond_true = slot_free && (mask_ff == '0 || rest == '0);
         COND_SLOT_FREE: cond_true = slot_free;
         default:        cond_true = 1'b0;
      endcase
      upc_in = cond_true ? uword.go_true : uword.go_false;
   end

   // Datapath next values
   always_comb begin
      grid_side_in    = grid_side_ff;
      radius_in       = radius_ff;
      center_index_in = center_index_ff;
      rem_in          = rem_ff;
      quo_in          = quo_ff;
      div_cnt_in      = div_cnt_ff;
      center_x_in     = center_x_ff;
      center_y_in     = center_y_ff;
      center_z_in     = center_z_ff;
      mask_in         = mask_ff;
      side_sq_in      = SQ_W'(side) * SQ_W'(side);
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      rsp_index_in    = rsp_index_ff;
      rsp_status_in   = rsp_status_ff;
      rsp_last_in     = rsp_last_ff;
      rsp_load        = 1'b0;

      if (csr_valid) begin
         case (csr_addr_type'(csr_index))
            CSR_GRID_SIDE: grid_side_in = csr_data;
            CSR_RADIUS:    radius_in    = csr_data[0];
            default:       grid_side_in = grid_side_ff;
         endcase
      end

      if (req_fire) begin
         center_index_in = req_center_index;
         quo_in          = req_center_index;
         rem_in          = '0;
         div_cnt_in      = '0;
      end

      if (uword.div_step) begin
         rem_in     = part_rem;
         quo_in     = part_quo;
         div_cnt_in = div_cnt_ff + DIV_CNT_W'(1);
      end

      // quotient of the first pass becomes the dividend of the second
      if (uword.move_x) begin
         center_x_in = rem_ff[COORD_W-1:0];
         rem_in      = '0;
         div_cnt_in  = '0;
      end

      if (uword.take_yz && !outside) begin
         center_y_in = rem_ff[COORD_W-1:0];
         center_z_in = quo_ff[COORD_W-1:0];
      end

      if (uword.make_mask) begin
         mask_in = mask_new;
      end

      if (uword.emit_nbr && slot_free) begin
         rsp_load = 1'b1;
         if (mask_ff == '0) begin
            rsp_index_in  = '0;
            rsp_status_in = STATUS_EMPTY;
            rsp_last_in   = 1'b1;
         end else begin
            rsp_index_in  = nbr_index;
            rsp_status_in = STATUS_OK;
            rsp_last_in   = rest == '0;
            mask_in       = rest;
         end
      end

      if (uword.emit_err && slot_free) begin
         rsp_load      = 1'b1;
         rsp_index_in  = '0;
         rsp_status_in = STATUS_OUTSIDE;
         rsp_last_in   = 1'b1;
      end

      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff       <= UPC_WAIT;
         grid_side_ff <= CSR_DATA_W'(64);
         radius_ff    <= 1'b1;
         div_cnt_ff   <= '0;
         mask_ff      <= '0;
         center_x_ff  <= '0;
         center_y_ff  <= '0;
         center_z_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         upc_ff       <= upc_in;
         grid_side_ff <= grid_side_in;
         radius_ff    <= radius_in;
         div_cnt_ff   <= div_cnt_in;
         mask_ff      <= mask_in;
         center_x_ff  <= center_x_in;
         center_y_ff  <= center_y_in;
         center_z_ff  <= center_z_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      center_index_ff <= center_index_in;
      rem_ff          <= rem_in;
      quo_ff          <= quo_in;
      side_sq_ff      <= side_sq_in;
      rsp_index_ff    <= rsp_index_in;
      rsp_status_ff   <= rsp_status_in;
      rsp_last_ff     <= rsp_last_in;
   end

   assign req_ready          = uword.take_req;
   assign csr_ready          = 1'b1;
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_neighbor_index = rsp_index_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_last           = rsp_last_ff;

   // the final word of a run hands control straight back to the wait step
   a_last_returns: assert property (@(posedge clock) disable iff (reset)
      (rsp_load && rsp_last_in) |=> (upc_ff == UPC_WAIT))
      else $error("sequencer did not return to wait after the final word");

   // a neighbour word never points at the centre voxel
   a_not_center: assert property (@(posedge clock) disable iff (reset)
      (upc_ff == UPC_EMIT && slot_free && mask_ff != '0) |-> (nbr_index != center_index_ff))
      else $error("neighbour index equals the centre index");

   // radius zero leaves no candidates to emit
   a_radius_zero: assert property (@(posedge clock) disable iff (reset)
      (upc_ff == UPC_EMIT && !radius_ff) |-> (mask_ff == '0))
      else $error("candidate mask not empty with radius zero");

endmodule
